[rtl/ttal_pkg.sv]
// Shared types and codes for the ticket admission controller.
// Depends on nothing; ttal_csr, ttal_ctrl, the top level and the testbench import it.
package ttal_pkg;

   // Input commands
   localparam logic [2:0] CMD_GATE_REG   = 3'd0;
   localparam logic [2:0] CMD_GATE_LOAD  = 3'd1;
   localparam logic [2:0] CMD_GATE_CLOSE = 3'd2;
   localparam logic [2:0] CMD_OPEN       = 3'd3;
   localparam logic [2:0] CMD_CLOSE      = 3'd4;
   localparam logic [2:0] CMD_TICK       = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_SEND  = 2'd0;
   localparam logic [1:0] KIND_QUEUE = 2'd1;
   localparam logic [1:0] KIND_KICK  = 2'd2;

   // Register indexes
   localparam logic REG_TICKET_LIMIT = 1'b0;
   localparam logic REG_CAPACITY     = 1'b1;

   localparam logic [30:0] MARK_MAX = 31'h7FFF_FFFF;
   localparam logic [23:0] CNT_MAX  = 24'hFF_FFFF;

   typedef struct packed {
      logic [4:0]  ticket_limit;
      logic [23:0] client_capacity;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] client;
      logic [3:0]  gate;
      logic [30:0] pos;
   } result_type;

endpackage

[rtl/ttal_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
interface ttal_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [3:0]  gate_index;
   logic [19:0] gate_load;
   logic [31:0] client_id;
   modport source(output valid, command, gate_index, gate_load, client_id, input ready);
   modport sink(input valid, command, gate_index, gate_load, client_id, output ready);
endinterface

interface ttal_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] target_client;
   logic [3:0]  chosen_gate;
   logic [30:0] queue_position;
   logic        last;
   modport source(output valid, kind, target_client, chosen_gate, queue_position, last,
                  input ready);
   modport sink(input valid, kind, target_client, chosen_gate, queue_position, last,
                output ready);
endinterface

[rtl/ttal_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module ttal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/ttal_csr.sv]
// APB-style configuration registers: ticket limit and client capacity.
// Depends on ttal_pkg.
module ttal_csr
   import ttal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);
   cfg_type cfg_ff;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_TICKET_LIMIT: cfg_ff.ticket_limit    <= pwdata[4:0];
            REG_CAPACITY:     cfg_ff.client_capacity <= pwdata[23:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (paddr[2])
         REG_TICKET_LIMIT: prdata = {27'd0, cfg_ff.ticket_limit};
         REG_CAPACITY:     prdata = {8'd0, cfg_ff.client_capacity};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

[rtl/ttal_ctrl.sv]
// Admission sequencer: gate load RAM, ticket slot RAM, scans and result register.
// Depends on ttal_pkg, ttal_if and ttal_ram.
module ttal_ctrl
   import ttal_pkg::*;
#(
   parameter int NUM_GATES    = 16,
   parameter int TICKET_SLOTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   ttal_req_if.sink      req,
   ttal_rsp_if.source    rsp
);
   localparam int GW  = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
   localparam int TW  = (TICKET_SLOTS > 1) ? $clog2(TICKET_SLOTS) : 1;
   localparam int MXN = (NUM_GATES > TICKET_SLOTS) ? NUM_GATES : TICKET_SLOTS;
   localparam int SW  = $clog2(MXN + 1);
   localparam int CW  = $clog2(TICKET_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_GSCAN, ST_TCALC, ST_WSCAN, ST_WEMIT, ST_CSCAN, ST_PUSH
   } state_type;

   state_type            state_ff;
   logic                 op_tick_ff;
   logic [31:0]          client_ff;
   logic [SW-1:0]        scan_ff;
   logic                 q_vld_ff;
   logic [SW-1:0]        q_idx_ff;
   logic                 best_vld_ff;
   logic [GW-1:0]        best_ff;
   logic [19:0]          best_load_ff;
   logic [23:0]          sum_ff;
   logic [30:0]          issued_ff;
   logic [30:0]          pass_ff;
   logic [23:0]          load_total_ff;
   logic [23:0]          extra_ff;
   logic [NUM_GATES-1:0] present_ff;
   logic [TICKET_SLOTS-1:0] used_ff;
   logic                 prev_vld_ff;
   logic [30:0]          prev_ff;
   logic                 found_ff;
   logic [30:0]          pick_tkt_ff;
   logic [31:0]          pick_cli_ff;
   result_type           pend_ff;
   logic                 pend_vld_ff;
   result_type           out_ff;
   logic                 out_last_ff;
   logic                 out_vld_ff;

   // memory ports
   logic          g_wr_en;
   logic [GW-1:0] g_wr_addr;
   logic [19:0]   g_wr_data;
   logic          g_rd_en;
   logic [19:0]   g_rd_data;
   logic          s_wr_en;
   logic [TW-1:0] s_wr_addr;
   logic          s_rd_en;
   logic [62:0]   s_rd_data;

   logic [CW-1:0] used_cnt;
   logic [TW-1:0] free_idx;
   logic          gi_ok;
   logic [GW-1:0] gi;
   logic          out_free;
   logic          out_load;
   logic [30:0]   rd_tkt;
   logic [31:0]   rd_cli;
   logic [GW-1:0] q_gate;
   logic [TW-1:0] q_slot;
   logic          scan_more;
   logic          pick_passed;
   logic [24:0]   sum_add;
   logic [24:0]   open_load;
   logic [30:0]   waiting;
   logic [30:0]   spare;

   ttal_ram #(.WIDTH(20), .DEPTH(NUM_GATES), .AW(GW)) u_gate_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (g_rd_en),
      .rd_addr (GW'(scan_ff)),
      .rd_data (g_rd_data)
   );

   ttal_ram #(.WIDTH(63), .DEPTH(TICKET_SLOTS), .AW(TW)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data ({issued_ff + 31'd1, req.client_id}),
      .rd_en   (s_rd_en),
      .rd_addr (TW'(scan_ff)),
      .rd_data (s_rd_data)
   );

   assign rd_tkt   = s_rd_data[62:32];
   assign rd_cli   = s_rd_data[31:0];
   assign q_gate   = GW'(q_idx_ff);
   assign q_slot   = TW'(q_idx_ff);
   assign gi_ok    = 32'(req.gate_index) < 32'(NUM_GATES);
   assign gi       = GW'(req.gate_index);
   assign out_free = !out_vld_ff || rsp.ready;
   assign out_load = out_free && ((state_ff == ST_PUSH) ||
                                  (state_ff == ST_WEMIT && pend_vld_ff));
   assign used_cnt = CW'($countones(used_ff));
   assign sum_add  = {1'b0, sum_ff} + {5'd0, g_rd_data};
   assign open_load = {1'b0, load_total_ff} + {1'b0, extra_ff};
   assign waiting  = issued_ff - pass_ff;
   assign spare    = {7'd0, cfg.client_capacity - load_total_ff};
   assign pick_passed = pick_tkt_ff <= pass_ff;

   // lowest free ticket slot
   always_comb begin
      free_idx = '0;
      for (int i = TICKET_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = TW'(i);
         end
      end
   end

   // memory control
   always_comb begin
      scan_more = 1'b0;
      if (state_ff == ST_GSCAN) begin
         scan_more = scan_ff < SW'(NUM_GATES);
      end else if (state_ff == ST_WSCAN || state_ff == ST_CSCAN) begin
         scan_more = scan_ff < SW'(TICKET_SLOTS);
      end
      g_rd_en   = (state_ff == ST_GSCAN) && scan_more;
      s_rd_en   = (state_ff == ST_WSCAN || state_ff == ST_CSCAN) && scan_more;
      g_wr_en   = 1'b0;
      g_wr_addr = gi;
      g_wr_data = '0;
      s_wr_en   = 1'b0;
      s_wr_addr = free_idx;
      if (state_ff == ST_IDLE && req.valid && gi_ok) begin
         if (req.command == CMD_GATE_REG) begin
            g_wr_en = 1'b1;
         end else if (req.command == CMD_GATE_LOAD && present_ff[gi]) begin
            g_wr_en   = 1'b1;
            g_wr_data = req.gate_load;
         end
      end
      if (state_ff == ST_IDLE && req.valid && req.command == CMD_OPEN &&
          cfg.ticket_limit != 5'd0 &&
          32'(used_cnt) < 32'(cfg.ticket_limit) && 32'(used_cnt) < 32'(TICKET_SLOTS) &&
          !(issued_ff == pass_ff && open_load < {1'b0, cfg.client_capacity}) &&
          issued_ff < MARK_MAX) begin
         s_wr_en = 1'b1;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         q_vld_ff      <= 1'b0;
         present_ff    <= '0;
         used_ff       <= '0;
         issued_ff     <= '0;
         pass_ff       <= '0;
         load_total_ff <= '0;
         extra_ff      <= '0;
         out_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         prev_vld_ff   <= 1'b0;
         best_vld_ff   <= 1'b0;
         op_tick_ff    <= 1'b0;
      end else begin
         if (rsp.ready && !out_load) begin
            out_vld_ff <= 1'b0;
         end
         if (state_ff == ST_GSCAN || state_ff == ST_WSCAN || state_ff == ST_CSCAN) begin
            q_vld_ff <= scan_more;
            q_idx_ff <= scan_ff;
            if (scan_more) begin
               scan_ff <= scan_ff + SW'(1);
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  client_ff <= req.client_id;
                  scan_ff   <= '0;
                  q_vld_ff  <= 1'b0;
                  best_vld_ff <= 1'b0;
                  unique case (req.command)
                     CMD_GATE_REG:   if (gi_ok) present_ff[gi] <= 1'b1;
                     CMD_GATE_CLOSE: if (gi_ok) present_ff[gi] <= 1'b0;
                     CMD_OPEN: begin
                        op_tick_ff <= 1'b0;
                        // a new ticket is issued exactly when the slot RAM is written
                        pend_ff    <= '{kind: s_wr_en ? KIND_QUEUE : KIND_KICK,
                                        client: req.client_id, gate: 4'd0,
                                        pos: s_wr_en ? issued_ff + 31'd1 - pass_ff : 31'd0};
                        if (cfg.ticket_limit == 5'd0) begin
                           state_ff <= ST_GSCAN;
                        end else if (32'(used_cnt) >= 32'(cfg.ticket_limit) ||
                                     32'(used_cnt) >= 32'(TICKET_SLOTS)) begin
                           state_ff <= ST_PUSH;
                        end else if (issued_ff == pass_ff &&
                                     open_load < {1'b0, cfg.client_capacity}) begin
                           if (extra_ff != CNT_MAX) extra_ff <= extra_ff + 24'd1;
                           state_ff <= ST_GSCAN;
                        end else if (issued_ff < MARK_MAX) begin
                           issued_ff         <= issued_ff + 31'd1;
                           used_ff[free_idx] <= 1'b1;
                           state_ff          <= ST_PUSH;
                        end else begin
                           state_ff <= ST_GSCAN;
                        end
                     end
                     CMD_CLOSE: if (cfg.ticket_limit != 5'd0) state_ff <= ST_CSCAN;
                     CMD_TICK: begin
                        op_tick_ff <= 1'b1;
                        extra_ff   <= '0;
                        sum_ff     <= '0;
                        state_ff   <= ST_GSCAN;
                     end
                     default: ;
                  endcase
               end
            end
            // one gate per cycle: least load and load sum
            ST_GSCAN: begin
               if (q_vld_ff && present_ff[q_gate]) begin
                  sum_ff <= sum_add[24] ? CNT_MAX : sum_add[23:0];
                  if (!best_vld_ff || best_load_ff > g_rd_data) begin
                     best_vld_ff  <= 1'b1;
                     best_ff      <= q_gate;
                     best_load_ff <= g_rd_data;
                  end
               end
               if (!scan_more && !q_vld_ff) begin
                  scan_ff <= '0;
                  if (op_tick_ff) begin
                     load_total_ff <= sum_ff;
                     state_ff      <= ST_TCALC;
                  end else begin
                     pend_ff.kind <= best_vld_ff ? KIND_SEND : KIND_KICK;
                     pend_ff.gate <= best_vld_ff ? 4'(best_ff) : 4'd0;
                     state_ff     <= ST_PUSH;
                  end
               end
            end
            // advance pass mark by spare capacity
            ST_TCALC: begin
               prev_vld_ff <= 1'b0;
               found_ff    <= 1'b0;
               pend_vld_ff <= 1'b0;
               if (issued_ff > pass_ff && cfg.client_capacity > load_total_ff) begin
                  pass_ff  <= (spare > waiting) ? issued_ff : pass_ff + spare;
                  state_ff <= ST_WSCAN;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            // find the next ticket above the previous one
            ST_WSCAN: begin
               if (q_vld_ff && used_ff[q_slot] && (!prev_vld_ff || rd_tkt > prev_ff) &&
                   (!found_ff || rd_tkt < pick_tkt_ff)) begin
                  found_ff    <= 1'b1;
                  pick_tkt_ff <= rd_tkt;
                  pick_cli_ff <= rd_cli;
               end
               if (!scan_more && !q_vld_ff) begin
                  scan_ff  <= '0;
                  state_ff <= ST_WEMIT;
               end
            end
            // release the held item once the next one is known
            ST_WEMIT: begin
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     out_ff      <= pend_ff;
                     out_last_ff <= !found_ff;
                     out_vld_ff  <= 1'b1;
                  end
                  if (found_ff) begin
                     pend_vld_ff    <= 1'b1;
                     pend_ff.client <= pick_cli_ff;
                     if (pick_passed) begin
                        pend_ff.kind <= best_vld_ff ? KIND_SEND : KIND_KICK;
                        pend_ff.gate <= best_vld_ff ? 4'(best_ff) : 4'd0;
                        pend_ff.pos  <= '0;
                        if (extra_ff != CNT_MAX) extra_ff <= extra_ff + 24'd1;
                     end else begin
                        pend_ff.kind <= KIND_QUEUE;
                        pend_ff.gate <= 4'd0;
                        pend_ff.pos  <= pick_tkt_ff - pass_ff;
                     end
                     prev_vld_ff <= 1'b1;
                     prev_ff     <= pick_tkt_ff;
                     found_ff    <= 1'b0;
                     state_ff    <= ST_WSCAN;
                  end else begin
                     pend_vld_ff <= 1'b0;
                     state_ff    <= ST_IDLE;
                  end
               end
            end
            // drop every slot of the closing client
            ST_CSCAN: begin
               if (q_vld_ff && used_ff[q_slot] && rd_cli == client_ff) begin
                  used_ff[q_slot] <= 1'b0;
               end
               if (!scan_more && !q_vld_ff) begin
                  scan_ff  <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_PUSH: begin
               if (out_free) begin
                  out_ff      <= pend_ff;
                  out_last_ff <= 1'b1;
                  out_vld_ff  <= 1'b1;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready          = state_ff == ST_IDLE;
   assign rsp.valid          = out_vld_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.target_client  = out_ff.client;
   assign rsp.chosen_gate    = out_ff.gate;
   assign rsp.queue_position = out_ff.pos;
   assign rsp.last           = out_last_ff;
endmodule

[rtl/ticket_admission_least_load.sv]
// Top level of the ticket admission controller: CSR block and sequencer.
// Depends on ttal_pkg, ttal_if, ttal_csr, ttal_ctrl.
//
// Gate register, load report and gate close items are done in the idle state.
// A client open runs a full gate scan through the gate load RAM when the
// client goes to a gate. A client close scans the slot RAM, one slot RAM read
// per cycle. A tick runs the gate scan and the pass mark update, then, if the
// pass mark moves, a full slot RAM scan for each held ticket plus one, since
// every result needs a full pass to find the next ticket in ascending order.
// Results wait in an output register; any cycle it stays full adds a stall.
// The next item is accepted whenever the sequencer is idle.
module ticket_admission_least_load
   import ttal_pkg::*;
#(
   parameter int NUM_GATES    = 16,
   parameter int TICKET_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ttal_req_if.sink    req_bus,
   ttal_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type cfg;

   ttal_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ttal_ctrl #(.NUM_GATES(NUM_GATES), .TICKET_SLOTS(TICKET_SLOTS)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );
endmodule

[tb/ticket_admission_least_load_tb.sv]
// Self-checking testbench for ticket_admission_least_load: directed table then random items,
// every result checked against an in-bench admission predictor.
// Depends on ttal_pkg, ttal_if and the RTL of ticket_admission_least_load.
module ticket_admission_least_load_tb
   import ttal_pkg::*;
();

   localparam int GATES       = 16;
   localparam int SLOTS       = 16;
   localparam int IDLE_LIMIT  = 5000;
   localparam int SETTLE      = 400;
   localparam int LONG_HOLD   = 300;
   localparam logic [2:0] CSR_LIMIT_ADDR    = 3'd0;
   localparam logic [2:0] CSR_CAPACITY_ADDR = 3'd4;

   typedef struct {
      result_type res;
      logic       last;
   } admit_result_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [3:0]  gate;
      logic [19:0] load;
      logic [31:0] client;
      bit          typed;
      logic [1:0]  kind;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ttal_req_if req_ch ();
   ttal_rsp_if rsp_ch ();

   ticket_admission_least_load u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Predictor state
   bit [4:0]  pr_limit;
   bit [23:0] pr_capacity;
   bit        pr_gate_on   [GATES];
   bit [19:0] pr_gate_load [GATES];
   bit        pr_slot_on   [SLOTS];
   bit [30:0] pr_slot_tkt  [SLOTS];
   bit [31:0] pr_slot_cid  [SLOTS];
   bit [30:0] pr_issued;
   bit [30:0] pr_pass;
   bit [23:0] pr_load_sum;
   bit [23:0] pr_extra;

   admit_result_type expected_admits[$];
   bit            failed;
   bit            hold_request;
   bit            quiet_sides;
   logic [31:0]   client_pool [8];

   // Register settings of the random phases
   logic [4:0]  limits [5] = '{5'd1, 5'd5, 5'd16, 5'd31, 5'd0};
   logic [23:0] caps   [5] = '{24'd0, 24'd3, 24'hFF_FFFF, 24'd50, 24'd2};

   function automatic void push_admit(logic [1:0] kind, logic [31:0] cid, logic [3:0] gate,
                                      logic [30:0] pos);
      admit_result_type a;
      a.res.kind   = kind;
      a.res.client = cid;
      a.res.gate   = gate;
      a.res.pos    = pos;
      a.last       = 1'b0;
      expected_admits.push_back(a);
   endfunction

   function automatic void bump_extra();
      if (pr_extra < CNT_MAX) pr_extra++;
   endfunction

   // Least-loaded present gate, lowest index on ties; kick when none
   function automatic void route_client(logic [31:0] cid);
      int best;
      best = -1;
      for (int g = 0; g < GATES; g++)
         if (pr_gate_on[g] && (best < 0 || pr_gate_load[best] > pr_gate_load[g])) best = g;
      if (best < 0) push_admit(KIND_KICK, cid, 4'd0, 31'd0);
      else push_admit(KIND_SEND, cid, best[3:0], 31'd0);
   endfunction

   function automatic void open_client(logic [31:0] cid);
      int used;
      int spot;
      used = 0;
      spot = -1;
      if (pr_limit > 0) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (pr_slot_on[i]) used++;
            else if (spot < 0) spot = i;
         end
         if (used >= pr_limit || used >= SLOTS) begin
            push_admit(KIND_KICK, cid, 4'd0, 31'd0);
            return;
         end
         if (pr_issued == pr_pass && 25'(pr_load_sum) + 25'(pr_extra) < 25'(pr_capacity)) begin
            bump_extra();
         end else if (pr_issued < MARK_MAX) begin
            pr_issued++;
            pr_slot_on[spot]  = 1'b1;
            pr_slot_tkt[spot] = pr_issued;
            pr_slot_cid[spot] = cid;
            push_admit(KIND_QUEUE, cid, 4'd0, pr_issued - pr_pass);
            return;
         end
      end
      route_client(cid);
   endfunction

   // Tick: sum loads, advance the pass mark, walk tickets in ascending order
   function automatic void tick_walk();
      bit [35:0] sum;
      bit [30:0] waiting;
      bit [30:0] spare;
      bit [30:0] prev;
      bit        have_prev;
      int        pick;
      sum = '0;
      pr_extra = '0;
      for (int g = 0; g < GATES; g++)
         if (pr_gate_on[g]) sum += pr_gate_load[g];
      pr_load_sum = (sum > CNT_MAX) ? CNT_MAX : sum[23:0];
      if (pr_issued > pr_pass && pr_capacity > pr_load_sum) begin
         waiting   = pr_issued - pr_pass;
         spare     = 31'(pr_capacity - pr_load_sum);
         pr_pass   = (spare > waiting) ? pr_issued : pr_pass + spare;
         have_prev = 1'b0;
         prev      = '0;
         forever begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (!pr_slot_on[i]) continue;
               if (have_prev && pr_slot_tkt[i] <= prev) continue;
               if (pick < 0 || pr_slot_tkt[i] < pr_slot_tkt[pick]) pick = i;
            end
            if (pick < 0) break;
            prev      = pr_slot_tkt[pick];
            have_prev = 1'b1;
            if (pr_slot_tkt[pick] <= pr_pass) begin
               route_client(pr_slot_cid[pick]);
               bump_extra();
            end else begin
               push_admit(KIND_QUEUE, pr_slot_cid[pick], 4'd0, pr_slot_tkt[pick] - pr_pass);
            end
         end
      end
   endfunction

   function automatic void predict_admission(logic [2:0] cmd, logic [3:0] gate,
                                             logic [19:0] load, logic [31:0] cid);
      int before_n;
      before_n = expected_admits.size();
      case (cmd)
         CMD_GATE_REG: begin
            pr_gate_on[gate]   = 1'b1;
            pr_gate_load[gate] = '0;
         end
         CMD_GATE_LOAD: if (pr_gate_on[gate]) pr_gate_load[gate] = load;
         CMD_GATE_CLOSE: pr_gate_on[gate] = 1'b0;
         CMD_OPEN: open_client(cid);
         CMD_CLOSE: begin
            if (pr_limit > 0)
               for (int i = 0; i < SLOTS; i++)
                  if (pr_slot_on[i] && pr_slot_cid[i] == cid) pr_slot_on[i] = 1'b0;
         end
         CMD_TICK: tick_walk();
         default: ;
      endcase
      if (expected_admits.size() > before_n) expected_admits[expected_admits.size() - 1].last = 1'b1;
   endfunction

   // Item driver; valid stays high across back-to-back items
   task automatic send_item(logic [2:0] cmd, logic [3:0] gate, logic [19:0] load,
                            logic [31:0] cid);
      int gap;
      gap = quiet_sides ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.gate_index <= gate;
      req_ch.gate_load  <= load;
      req_ch.client_id  <= cid;
      do @(posedge clock); while (!req_ch.ready);
      predict_admission(cmd, gate, load, cid);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == CSR_LIMIT_ADDR) pr_limit = data[4:0];
      else pr_capacity = data[23:0];
   endtask

   // Wait until all results are in, then let a close or tick finish its scan
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_admits.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [4:0] limit, logic [23:0] cap);
      drain_results();
      csr_write(CSR_LIMIT_ADDR, {27'd0, limit});
      csr_write(CSR_CAPACITY_ADDR, {8'd0, cap});
   endtask

   task automatic random_item();
      int          pick;
      logic [2:0]  cmd;
      logic [19:0] load;
      logic [31:0] cid;
      pick = $urandom_range(0, 99);
      load = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40));
      cid  = ($urandom_range(0, 4) == 0) ? $urandom : client_pool[$urandom_range(0, 7)];
      if (pick < 10) cmd = CMD_GATE_REG;
      else if (pick < 24) cmd = CMD_GATE_LOAD;
      else if (pick < 29) cmd = CMD_GATE_CLOSE;
      else if (pick < 60) cmd = CMD_OPEN;
      else if (pick < 72) cmd = CMD_CLOSE;
      else if (pick < 94) cmd = CMD_TICK;
      else cmd = 3'($urandom_range(6, 7));
      send_item(cmd, 4'($urandom), load, cid);
   endtask

   // Result receiver and checker
   initial begin : receiver
      int          gap;
      admit_result_type want;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = quiet_sides ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (expected_admits.size() == 0) begin
            $error("unexpected result: kind %0d client %h", rsp_ch.kind, rsp_ch.target_client);
            failed = 1'b1;
         end else begin
            want = expected_admits.pop_front();
            if (rsp_ch.kind !== want.res.kind) begin
               $error("kind: expected %0d actual %0d", want.res.kind, rsp_ch.kind);
               failed = 1'b1;
            end
            if (rsp_ch.target_client !== want.res.client) begin
               $error("target_client: expected %h actual %h", want.res.client,
                      rsp_ch.target_client);
               failed = 1'b1;
            end
            if (rsp_ch.chosen_gate !== want.res.gate) begin
               $error("chosen_gate: expected %0d actual %0d", want.res.gate, rsp_ch.chosen_gate);
               failed = 1'b1;
            end
            if (rsp_ch.queue_position !== want.res.pos) begin
               $error("queue_position: expected %0d actual %0d", want.res.pos,
                      rsp_ch.queue_position);
               failed = 1'b1;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, rsp_ch.last);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("ticket_admission_least_load: mismatch");
            $finish;
         end
      end
   end

   stim_row_type directed [] = '{
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0001, 1'b1, KIND_KICK},
      '{CMD_GATE_REG,   4'd3,  20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_REG,   4'd15, 20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_LOAD,  4'd3,  20'hF_FFFF,  32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_LOAD,  4'd15, 20'd5,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_LOAD,  4'd0,  20'd7,       32'd0,         1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0000, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'hFFFF_FFFF, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0010, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0011, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0011, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0012, 1'b0, KIND_SEND},
      '{CMD_OPEN,       4'd0,  20'd0,       32'h0000_0013, 1'b1, KIND_KICK},
      '{CMD_CLOSE,      4'd0,  20'd0,       32'h0000_0011, 1'b0, KIND_SEND},
      '{CMD_CLOSE,      4'd0,  20'd0,       32'hDEAD_BEEF, 1'b0, KIND_SEND},
      '{3'd6,           4'd1,  20'd1,       32'h1,         1'b0, KIND_SEND},
      '{3'd7,           4'd2,  20'd2,       32'h2,         1'b0, KIND_SEND},
      '{CMD_TICK,       4'd0,  20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_REG,   4'd3,  20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_CLOSE, 4'd15, 20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_TICK,       4'd0,  20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_GATE_CLOSE, 4'd3,  20'd0,       32'd0,         1'b0, KIND_SEND},
      '{CMD_TICK,       4'd0,  20'd0,       32'd0,         1'b0, KIND_SEND}
   };

   // Main sequence
   initial begin : stimulus
      failed       = 1'b0;
      hold_request = 1'b0;
      quiet_sides  = 1'b0;
      reset        <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_TICK;
      req_ch.gate_index <= '0;
      req_ch.gate_load  <= '0;
      req_ch.client_id  <= '0;
      pr_limit    = '0;
      pr_capacity = '0;
      pr_issued   = '0;
      pr_pass     = '0;
      pr_load_sum = '0;
      pr_extra    = '0;
      for (int i = 0; i < GATES; i++) pr_gate_on[i] = 1'b0;
      for (int i = 0; i < SLOTS; i++) pr_slot_on[i] = 1'b0;
      for (int i = 0; i < 8; i++) client_pool[i] = $urandom;
      client_pool[0] = 32'h0000_0000;
      client_pool[1] = 32'hFFFF_FFFF;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: reset config first, then a small queueing setup
      foreach (directed[i]) begin
         if (i == 1) configure(5'd4, 24'd2);
         send_item(directed[i].cmd, directed[i].gate, directed[i].load, directed[i].client);
         if (directed[i].typed) begin
            if (expected_admits.size() == 0) begin
               $error("kind: expected %0d actual none", directed[i].kind);
               failed = 1'b1;
            end else if (expected_admits[expected_admits.size() - 1].res.kind !=
                         directed[i].kind) begin
               $error("kind: expected %0d actual %0d", directed[i].kind,
                      expected_admits[expected_admits.size() - 1].res.kind);
               failed = 1'b1;
            end
         end
      end

      // Random phases over several register settings
      for (int p = 0; p < 5; p++) begin
         configure(limits[p], caps[p]);
         quiet_sides = (p == 2);
         for (int n = 0; n < 60; n++) begin
            if (p == 1 && n == 20) hold_request = 1'b1;
            random_item();
         end
      end
      quiet_sides = 1'b0;
      drain_results();

      if (!failed)
         $display("ticket_admission_least_load: match");
      else
         $display("ticket_admission_least_load: mismatch");
      $finish;
   end

endmodule
